FILE: hw/rtl/abhd_pkg.sv
package abhd_pkg;

    localparam int PERIOD_W   = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // shown / requested modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_HAZARD = 2'd1;
    localparam logic [1:0] MODE_ALARM  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // item operations
    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_ALL_OFF = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_INVERT       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_PERIOD = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HAZARD_PERIOD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TIME    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUZZER_EN    = 3'd4;

    // register reset values
    localparam logic                RST_INVERT        = 1'b0;
    localparam logic [PERIOD_W-1:0] RST_ALARM_PERIOD  = 16'd250;
    localparam logic [PERIOD_W-1:0] RST_HAZARD_PERIOD = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_HOLD_TIME     = 16'd1000;
    localparam logic                RST_BUZZER_EN     = 1'b1;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic q_odd;
    } div_stat_t;

endpackage

FILE: hw/rtl/abhd_if.sv
interface abhd_item_if #(parameter int TIME_WIDTH = 40);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [1:0]            mode_in;
    logic [TIME_WIDTH-1:0] time_ms;

    modport source (output valid, output op, output mode_in, output time_ms, input ready);
    modport sink   (input valid, input op, input mode_in, input time_ms, output ready);
endinterface

interface abhd_result_if;
    logic       valid;
    logic       ready;
    logic       led_drive;
    logic       buzzer_drive;
    logic       led_write;
    logic       buzzer_write;
    logic       alarm_active;
    logic [1:0] shown_mode_out;

    modport source (output valid, output led_drive, output buzzer_drive, output led_write,
                    output buzzer_write, output alarm_active, output shown_mode_out,
                    input ready);
    modport sink   (input valid, input led_drive, input buzzer_drive, input led_write,
                    input buzzer_write, input alarm_active, input shown_mode_out,
                    output ready);
endinterface

FILE: hw/rtl/abhd_div.sv
module abhd_div #(
    parameter int TIME_WIDTH = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [TIME_WIDTH-1:0]         dividend,
    input  logic [abhd_pkg::PERIOD_W-1:0] divisor,
    output abhd_pkg::div_stat_t           stat
);
    import abhd_pkg::*;

    localparam int CNT_W = $clog2(TIME_WIDTH + 1);

    logic [TIME_WIDTH-1:0] dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]   dsr_reg, dsr_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  q_reg, q_next;

    logic [PERIOD_W:0] trial;
    logic [PERIOD_W:0] diff;
    logic              ge;

    // restoring division, one quotient bit per cycle, msb first
    assign trial = {rem_reg, dvd_reg[TIME_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(TIME_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[TIME_WIDTH-2:0], 1'b0};
            rem_next = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = ge;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;
    assign stat.q_odd = q_reg;

endmodule

FILE: hw/rtl/alarm_blink_hold_driver_core.sv
// channel   dir  beat contents
// item      in   op, mode_in, time_ms (TIME_WIDTH bits)
// result    out  led_drive, buzzer_drive, led_write, buzzer_write, alarm_active,
//                shown_mode_out
// cfg       in   cfg_we, cfg_addr, cfg_wdata (write only)
//
// one item at a time: hold/mode update, elapsed time, bit-serial divide (one
// quotient bit per cycle from the divider), result load; the next item is taken once
// the sequencer is back in idle after the result load; solid/normal LED skips the
// divide, all-off items skip both the elapsed time step and the divide
// reset needs no clearing pass; a new item is taken while a result waits
// a result that is not taken stalls the last step and holds the sequencer
module alarm_blink_hold_driver_core #(
    parameter int TIME_WIDTH = 40
) (
    input  logic                            clk,
    input  logic                            rst_n,
    abhd_item_if.sink                       item,
    abhd_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [abhd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [abhd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import abhd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HOLD = 5'b00010,
        S_ELAP = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    // configuration
    logic                invert_reg;
    logic [PERIOD_W-1:0] alarm_period_reg;
    logic [PERIOD_W-1:0] hazard_period_reg;
    logic [PERIOD_W-1:0] hold_time_reg;
    logic                buzzer_en_reg;

    // sequencer and block state
    state_t                state_reg, state_next;
    logic [1:0]            disp_mode_reg, disp_mode_next;
    logic                  mode_valid_reg, mode_valid_next;
    logic [TIME_WIDTH-1:0] phase_start_reg, phase_start_next;
    logic [TIME_WIDTH-1:0] deadline_reg, deadline_next;
    logic                  led_logical_reg, led_logical_next;
    logic                  buz_logical_reg, buz_logical_next;

    // captured item and working values
    logic                  op_reg, op_next;
    logic [1:0]            mode_reg, mode_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic                  led_reg, led_next;

    // result register
    logic       res_valid_reg, res_valid_next;
    logic       res_led_drive_reg, res_led_drive_next;
    logic       res_buz_drive_reg, res_buz_drive_next;
    logic       res_led_write_reg, res_led_write_next;
    logic       res_buz_write_reg, res_buz_write_next;
    logic       res_alarm_reg, res_alarm_next;
    logic [1:0] res_shown_reg, res_shown_next;

    // hold deadline and shown mode
    logic [1:0]            req;
    logic [1:0]            shown;
    logic [TIME_WIDTH:0]   hold_sum;
    logic [TIME_WIDTH-1:0] hold_sat;

    // blink setup
    logic [TIME_WIDTH-1:0] elapsed;
    logic [PERIOD_W-1:0]   period;
    logic [PERIOD_W-1:0]   half;
    logic                  div_start;
    div_stat_t             div_stat;

    // result load
    logic buz_level;
    logic res_free;

    // mode three counts as normal
    assign req = ((mode_reg == MODE_ALARM) || (mode_reg == MODE_HAZARD)) ? mode_reg
                                                                         : MODE_NORMAL;
    // deadline saturates at the top of the time range
    assign hold_sum = {1'b0, now_reg} + {{(TIME_WIDTH + 1 - PERIOD_W){1'b0}}, hold_time_reg};
    assign hold_sat = hold_sum[TIME_WIDTH] ? '1 : hold_sum[TIME_WIDTH-1:0];
    // deadline from an earlier alarming request keeps lower requests alarming
    assign shown = ((req != MODE_ALARM) && (now_reg < deadline_reg)) ? MODE_ALARM : req;

    // phase start is already updated here, elapsed wraps modulo the time range
    assign elapsed = now_reg - phase_start_reg;
    assign period  = (disp_mode_reg == MODE_ALARM) ? alarm_period_reg : hazard_period_reg;
    assign half    = (period[PERIOD_W-1:1] == '0) ? PERIOD_W'(1)
                                                  : {1'b0, period[PERIOD_W-1:1]};

    assign buz_level = (op_reg == OP_UPDATE) && (disp_mode_reg == MODE_ALARM);
    assign res_free  = !res_valid_reg || result.ready;

    abhd_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (half),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next         = state_reg;
        disp_mode_next     = disp_mode_reg;
        mode_valid_next    = mode_valid_reg;
        phase_start_next   = phase_start_reg;
        deadline_next      = deadline_reg;
        led_logical_next   = led_logical_reg;
        buz_logical_next   = buz_logical_reg;
        op_next            = op_reg;
        mode_next          = mode_reg;
        now_next           = now_reg;
        led_next           = led_reg;
        div_start          = 1'b0;
        res_valid_next     = res_valid_reg && !result.ready;
        res_led_drive_next = res_led_drive_reg;
        res_buz_drive_next = res_buz_drive_reg;
        res_led_write_next = res_led_write_reg;
        res_buz_write_next = res_buz_write_reg;
        res_alarm_next     = res_alarm_reg;
        res_shown_next     = res_shown_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next    = item.op;
                    mode_next  = item.mode_in;
                    now_next   = item.time_ms;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (op_reg == OP_ALL_OFF)
                begin
                    // all off: forget mode and hold, LED off
                    deadline_next   = '0;
                    mode_valid_next = 1'b0;
                    disp_mode_next  = MODE_NORMAL;
                    led_next        = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (req == MODE_ALARM)
                    begin
                        deadline_next = hold_sat;
                    end
                    // mode change restarts the blink in the on phase
                    if (!mode_valid_reg || (shown != disp_mode_reg))
                    begin
                        disp_mode_next   = shown;
                        mode_valid_next  = 1'b1;
                        phase_start_next = now_reg;
                    end
                    state_next = S_ELAP;
                end
            end
            S_ELAP:
            begin
                if ((disp_mode_reg == MODE_NORMAL) || (period == '0))
                begin
                    // normal is dark, zero period is solid on
                    led_next   = (disp_mode_reg != MODE_NORMAL);
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    // on during even half periods
                    led_next   = !div_stat.q_odd;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    led_logical_next   = led_reg;
                    res_led_write_next = (led_reg != led_logical_reg);
                    res_led_drive_next = led_reg ^ invert_reg;
                    // without a buzzer pin the level is kept and never driven
                    if (buzzer_en_reg)
                    begin
                        buz_logical_next   = buz_level;
                        res_buz_write_next = (buz_level != buz_logical_reg);
                        res_buz_drive_next = buz_level ^ invert_reg;
                    end
                    else
                    begin
                        res_buz_write_next = 1'b0;
                        res_buz_drive_next = 1'b0;
                    end
                    res_alarm_next = buz_level;
                    res_shown_next = disp_mode_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            disp_mode_reg   <= MODE_NORMAL;
            mode_valid_reg  <= 1'b0;
            phase_start_reg <= '0;
            deadline_reg    <= '0;
            led_logical_reg <= 1'b0;
            buz_logical_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            disp_mode_reg   <= disp_mode_next;
            mode_valid_reg  <= mode_valid_next;
            phase_start_reg <= phase_start_next;
            deadline_reg    <= deadline_next;
            led_logical_reg <= led_logical_next;
            buz_logical_reg <= buz_logical_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        mode_reg          <= mode_next;
        now_reg           <= now_next;
        led_reg           <= led_next;
        res_led_drive_reg <= res_led_drive_next;
        res_buz_drive_reg <= res_buz_drive_next;
        res_led_write_reg <= res_led_write_next;
        res_buz_write_reg <= res_buz_write_next;
        res_alarm_reg     <= res_alarm_next;
        res_shown_reg     <= res_shown_next;
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg        <= RST_INVERT;
            alarm_period_reg  <= RST_ALARM_PERIOD;
            hazard_period_reg <= RST_HAZARD_PERIOD;
            hold_time_reg     <= RST_HOLD_TIME;
            buzzer_en_reg     <= RST_BUZZER_EN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_INVERT:        invert_reg        <= cfg_wdata[0];
                CFG_ALARM_PERIOD:  alarm_period_reg  <= cfg_wdata[PERIOD_W-1:0];
                CFG_HAZARD_PERIOD: hazard_period_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_HOLD_TIME:     hold_time_reg     <= cfg_wdata[PERIOD_W-1:0];
                CFG_BUZZER_EN:     buzzer_en_reg     <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // ports
    assign item.ready            = (state_reg == S_IDLE);
    assign result.valid          = res_valid_reg;
    assign result.led_drive      = res_led_drive_reg;
    assign result.buzzer_drive   = res_buz_drive_reg;
    assign result.led_write      = res_led_write_reg;
    assign result.buzzer_write   = res_buz_write_reg;
    assign result.alarm_active   = res_alarm_reg;
    assign result.shown_mode_out = res_shown_reg;

`ifndef SYNTHESIS
    a_shown_known: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.shown_mode_out != MODE_UNUSED))
        else $error("shown mode out of range");

    a_alarm_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.alarm_active == (result.shown_mode_out == MODE_ALARM)))
        else $error("alarm flag disagrees with shown mode");

    a_no_buzzer_pin: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !buzzer_en_reg) |-> (!result.buzzer_write && !result.buzzer_drive))
        else $error("buzzer driven without a buzzer pin");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");
`endif

endmodule
